// File: sv/tpz_pkg.sv
// shared constants, types and tables of the torus point plotter
// no dependencies; every file but the channel interfaces imports this package
package tpz_pkg;

   localparam int FRAME_PIXELS = 8192;
   localparam int PIX_W        = $clog2(FRAME_PIXELS);
   localparam int CELL_EXT_W   = 17;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   // shared multiplier operand and product widths
   localparam int OP_A_W = 36;
   localparam int OP_B_W = 17;
   localparam int PROD_W = OP_A_W + OP_B_W;
   localparam int ACC_W  = PROD_W + 2;

   // shared divider widths
   localparam int NUM_W = 44;
   localparam int DEN_W = 37;

   localparam int LAST_STEP = 25;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_PLOT  = 2'd1,
      MODE_READ  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_ROT_ROW0      = 3'd0,
      CSR_ROT_ROW1      = 3'd1,
      CSR_ROT_ROW2      = 3'd2,
      CSR_MINOR_RADIUS  = 3'd3,
      CSR_MAJOR_RADIUS  = 3'd4,
      CSR_VIEW_DISTANCE = 3'd5,
      CSR_SCREEN_COLS   = 3'd6,
      CSR_SCREEN_ROWS   = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CALC,
      ST_DIVX,
      ST_DIVY,
      ST_DIVZ,
      ST_ADDR,
      ST_ADDR2,
      ST_TEST,
      ST_READ,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quot;
   } div_rsp_type;

   localparam logic [6:0] CHAR_SPACE = 7'h20;
   localparam logic [3:0] SHADE_MAX  = 4'd11;
   localparam logic [6:0] SHADE_CHARS [12] = '{
      7'h2e, 7'h2c, 7'h2d, 7'h7e, 7'h3a, 7'h3b,
      7'h3d, 7'h21, 7'h2a, 7'h23, 7'h24, 7'h40
   };

endpackage

// File: sv/tpz_channels.sv
// request and response channel interfaces of the torus point plotter
// no dependencies
interface tpz_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic signed [15:0] cos_theta;
   logic signed [15:0] sin_theta;
   logic signed [15:0] cos_phi;
   logic signed [15:0] sin_phi;
   logic [12:0]        pixel_index;

   modport source (
      output valid, mode, cos_theta, sin_theta, cos_phi, sin_phi, pixel_index,
      input  ready
   );
   modport sink (
      input  valid, mode, cos_theta, sin_theta, cos_phi, sin_phi, pixel_index,
      output ready
   );
endinterface

interface tpz_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] cell_index;
   logic [6:0]  char_code;
   logic        plotted;

   modport source (output valid, cell_index, char_code, plotted, input ready);
   modport sink   (input valid, cell_index, char_code, plotted, output ready);
endinterface

// File: sv/tpz_mul.sv
// shared signed multiplier with registered product
// depends on tpz_pkg
module tpz_mul (
   input  logic                               clock,
   input  logic signed [tpz_pkg::OP_A_W-1:0]  op_a,
   input  logic signed [tpz_pkg::OP_B_W-1:0]  op_b,
   output logic signed [tpz_pkg::PROD_W-1:0]  prod_ff
);
   import tpz_pkg::*;

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

// File: sv/tpz_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on tpz_pkg
module tpz_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tpz_pkg::div_req_type div_req,
   output tpz_pkg::div_rsp_type div_rsp
);
   import tpz_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;

   assign trial = {rem_ff, quot_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      den_in   = den_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (div_req.start) begin
         rem_in   = '0;
         quot_in  = div_req.num;
         den_in   = div_req.den;
         count_in = CNT_W'(NUM_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DEN_W]) begin
            rem_in  = diff[DEN_W-1:0];
            quot_in = {quot_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DEN_W-1:0];
            quot_in = {quot_ff[NUM_W-2:0], 1'b0};
         end
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
endmodule

// File: sv/torus_point_zbuffer_plotter_unit.sv
// top level of the torus point plotter: sequencer, frame and depth memories
// depends on tpz_pkg, tpz_channels, tpz_mul, tpz_div
//
// One word at a time: a clear word passes idle and output, a read word passes
// idle, read and output, and a plot word passes idle, 26 sequencer steps on the
// shared multiplier, three passes of the shared bit-serial divider for column,
// row and reciprocal depth, then address, memory read, depth test and output.
// Points that fail the eye-plane, column, row or frame-size test leave early.
// The result sits in an output register; the next request word is taken once
// the unit is idle, even while that result still waits. The memories power up
// undefined: clear every cell before reading it or plotting over it. The user
// must write configuration only while the unit is idle; nothing enforces it.
module torus_point_zbuffer_plotter_unit (
   input  logic                              clock,
   input  logic                              reset,
   tpz_req_if.sink                           req_chan,
   tpz_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [tpz_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tpz_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tpz_pkg::*;

   localparam logic [NUM_W-1:0] OOZ_NUM = NUM_W'(1) << 34;

   // floor divide by 2^14
   function automatic logic signed [OP_A_W-1:0] fl14(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] t;
      t = x >>> 14;
      return t[OP_A_W-1:0];
   endfunction

   function automatic logic signed [OP_B_W-1:0] coef(input logic [47:0] row, input int col);
      logic [47:0] sh;
      sh = row >> (16 * (2 - col));
      return OP_B_W'(signed'(sh[15:0]));
   endfunction

   function automatic logic [NUM_W-1:0] mag(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] t;
      t = (x < 0) ? -x : x;
      return t[NUM_W-1:0];
   endfunction

   // configuration
   logic [47:0] rot0_ff, rot1_ff, rot2_ff;
   logic [15:0] r1_ff, r2_ff, vd_ff;
   logic [7:0]  cols_ff, rows_ff;

   // control
   state_type   state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // latched request word
   mode_type           mode_ff, mode_in;
   logic signed [15:0] ct_ff, ct_in, st_ff, st_in, cp_ff, cp_in, sp_ff, sp_in;
   logic [CELL_EXT_W-1:0] pix_ff, pix_in;

   // datapath
   logic signed [OP_A_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [OP_A_W-1:0] v0_ff, v0_in, v2_ff, v2_in, u0_ff, u0_in, u2_ff, u2_in;
   logic signed [OP_A_W-1:0] p0_ff, p0_in, p1_ff, p1_in, n1_ff, n1_in, n2_ff, n2_in;
   logic signed [OP_A_W-1:0] z_ff, z_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, xnum_ff, xnum_in, ynum_ff, ynum_in;
   logic signed [ACC_W-1:0]  acc_sum, acc_diff;
   logic                     neg_ff, neg_in;
   logic [7:0]               xp_ff, xp_in, yp_ff, yp_in;
   logic [15:0]              ooz_ff, ooz_in;
   logic [CELL_EXT_W-1:0]    o_ff, o_in, o_sum;

   // pending result and output register
   logic [12:0] res_cell_ff, res_cell_in, rsp_cell_ff, rsp_cell_in;
   logic [6:0]  res_char_ff, res_char_in, rsp_char_ff, rsp_char_in;
   logic        res_plot_ff, res_plot_in, rsp_plot_ff, rsp_plot_in;

   // shared units
   logic signed [OP_A_W-1:0] op_a;
   logic signed [OP_B_W-1:0] op_b;
   logic signed [PROD_W-1:0] mul_prod;
   div_req_type              div_req;
   div_rsp_type              div_rsp;
   logic                     q_ok;
   logic [7:0]               q_val;

   // memories
   logic [6:0]       frame_mem [FRAME_PIXELS];
   logic [15:0]      depth_mem [FRAME_PIXELS];
   logic             mem_we;
   logic [PIX_W-1:0] mem_waddr, mem_raddr;
   logic [6:0]       mem_wchar, rd_char_ff;
   logic [15:0]      mem_wdepth, rd_depth_ff;

   // shading
   logic signed [OP_A_W:0] lum, lum_sh;
   logic [3:0]             shade_idx;

   tpz_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (mul_prod)
   );

   tpz_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign acc_sum  = acc_ff + ACC_W'(mul_prod);
   assign acc_diff = acc_ff - ACC_W'(mul_prod);
   assign o_sum    = CELL_EXT_W'(xp_ff) + CELL_EXT_W'(mul_prod[15:0]);

   // quotient check: a negative numerator only passes with a zero quotient,
   // and an empty frame passes nothing
   always_comb begin
      q_val = neg_ff ? 8'd0 : div_rsp.quot[7:0];
      if (state_ff == ST_DIVX) begin
         q_ok = (!neg_ff || div_rsp.quot == '0) && (div_rsp.quot < NUM_W'(cols_ff));
      end else begin
         q_ok = (!neg_ff || div_rsp.quot == '0) && (div_rsp.quot < NUM_W'(rows_ff));
      end
   end

   // normal dot (0,1,-1), times 8, clamped to the shade table
   always_comb begin
      lum    = (OP_A_W+1)'(n1_ff) - (OP_A_W+1)'(n2_ff);
      lum_sh = lum >>> 11;
      if (lum <= 0) begin
         shade_idx = 4'd0;
      end else if (lum_sh > (OP_A_W+1)'(SHADE_MAX)) begin
         shade_idx = SHADE_MAX;
      end else begin
         shade_idx = lum_sh[3:0];
      end
   end

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      mode_in     = mode_ff;
      ct_in       = ct_ff;
      st_in       = st_ff;
      cp_in       = cp_ff;
      sp_in       = sp_ff;
      pix_in      = pix_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      v0_in       = v0_ff;
      v2_in       = v2_ff;
      u0_in       = u0_ff;
      u2_in       = u2_ff;
      p0_in       = p0_ff;
      p1_in       = p1_ff;
      n1_in       = n1_ff;
      n2_in       = n2_ff;
      z_in        = z_ff;
      acc_in      = acc_ff;
      xnum_in     = xnum_ff;
      ynum_in     = ynum_ff;
      neg_in      = neg_ff;
      xp_in       = xp_ff;
      yp_in       = yp_ff;
      ooz_in      = ooz_ff;
      o_in        = o_ff;
      res_cell_in = res_cell_ff;
      res_char_in = res_char_ff;
      res_plot_in = res_plot_ff;
      rsp_cell_in = rsp_cell_ff;
      rsp_char_in = rsp_char_ff;
      rsp_plot_in = rsp_plot_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      op_a        = '0;
      op_b        = '0;
      div_req     = '0;
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_wchar   = CHAR_SPACE;
      mem_wdepth  = '0;
      mem_raddr   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            mem_raddr = PIX_W'(req_chan.pixel_index);
            if (req_chan.valid) begin
               mode_in     = mode_type'(req_chan.mode);
               ct_in       = req_chan.cos_theta;
               st_in       = req_chan.sin_theta;
               cp_in       = req_chan.cos_phi;
               sp_in       = req_chan.sin_phi;
               pix_in      = CELL_EXT_W'(req_chan.pixel_index);
               res_cell_in = 13'd0;
               res_char_in = CHAR_SPACE;
               res_plot_in = 1'b0;
               step_in     = '0;
               unique case (mode_type'(req_chan.mode))
                  MODE_CLEAR: begin
                     res_cell_in = req_chan.pixel_index;
                     if (CELL_EXT_W'(req_chan.pixel_index) < CELL_EXT_W'(FRAME_PIXELS)) begin
                        mem_we    = 1'b1;
                        mem_waddr = PIX_W'(req_chan.pixel_index);
                     end
                     state_in = ST_OUT;
                  end
                  MODE_READ: begin
                     res_cell_in = req_chan.pixel_index;
                     state_in    = ST_READ;
                  end
                  MODE_PLOT: state_in = ST_CALC;
                  MODE_NONE: state_in = ST_OUT;
               endcase
            end
         end

         ST_READ: begin
            if (pix_ff < CELL_EXT_W'(FRAME_PIXELS)) begin
               res_char_in = rd_char_ff;
            end
            state_in = ST_OUT;
         end

         // sequencer: steps 0 to 24 each issue one product, steps 1 to 25 use the one before
         ST_CALC: begin
            step_in = step_ff + 5'd1;
            unique case (step_ff)
               5'd0: begin op_a = OP_A_W'(signed'({1'b0, r1_ff})); op_b = OP_B_W'(ct_ff); end
               5'd1: begin
                  cx_in = (OP_A_W'(signed'({1'b0, r2_ff})) <<< 14) + OP_A_W'(mul_prod);
                  op_a  = OP_A_W'(signed'({1'b0, r1_ff}));
                  op_b  = OP_B_W'(st_ff);
               end
               5'd2: begin cy_in = OP_A_W'(mul_prod); op_a = cx_ff; op_b = OP_B_W'(cp_ff); end
               5'd3: begin
                  v0_in = fl14(ACC_W'(mul_prod)); op_a = cx_ff; op_b = OP_B_W'(sp_ff);
               end
               5'd4: begin
                  v2_in = fl14(ACC_W'(mul_prod)); op_a = OP_A_W'(ct_ff); op_b = OP_B_W'(cp_ff);
               end
               5'd5: begin
                  u0_in = fl14(ACC_W'(mul_prod)); op_a = OP_A_W'(ct_ff); op_b = OP_B_W'(sp_ff);
               end
               5'd6: begin
                  u2_in = fl14(ACC_W'(mul_prod)); op_a = v0_ff; op_b = coef(rot0_ff, 0);
               end
               5'd7:  begin acc_in = ACC_W'(mul_prod); op_a = cy_ff; op_b = coef(rot1_ff, 0); end
               5'd8:  begin acc_in = acc_sum; op_a = v2_ff; op_b = coef(rot2_ff, 0); end
               5'd9:  begin p0_in = fl14(acc_sum); op_a = v0_ff; op_b = coef(rot0_ff, 1); end
               5'd10: begin acc_in = ACC_W'(mul_prod); op_a = cy_ff; op_b = coef(rot1_ff, 1); end
               5'd11: begin acc_in = acc_sum; op_a = v2_ff; op_b = coef(rot2_ff, 1); end
               5'd12: begin p1_in = fl14(acc_sum); op_a = v0_ff; op_b = coef(rot0_ff, 2); end
               5'd13: begin acc_in = ACC_W'(mul_prod); op_a = cy_ff; op_b = coef(rot1_ff, 2); end
               5'd14: begin acc_in = acc_sum; op_a = v2_ff; op_b = coef(rot2_ff, 2); end
               5'd15: begin
                  z_in = fl14(acc_sum) + (OP_A_W'(signed'({1'b0, vd_ff})) <<< 14);
                  op_a = u0_ff;
                  op_b = coef(rot0_ff, 1);
               end
               5'd16: begin
                  acc_in = ACC_W'(mul_prod); op_a = OP_A_W'(st_ff); op_b = coef(rot1_ff, 1);
               end
               5'd17: begin acc_in = acc_sum; op_a = u2_ff; op_b = coef(rot2_ff, 1); end
               5'd18: begin n1_in = fl14(acc_sum); op_a = u0_ff; op_b = coef(rot0_ff, 2); end
               5'd19: begin
                  acc_in = ACC_W'(mul_prod); op_a = OP_A_W'(st_ff); op_b = coef(rot1_ff, 2);
               end
               5'd20: begin acc_in = acc_sum; op_a = u2_ff; op_b = coef(rot2_ff, 2); end
               5'd21: begin
                  n2_in = fl14(acc_sum);
                  op_a  = z_ff;
                  op_b  = OP_B_W'(signed'({1'b0, cols_ff}));
               end
               5'd22: begin acc_in = ACC_W'(mul_prod); op_a = p0_ff; op_b = OP_B_W'(60); end
               5'd23: begin
                  xnum_in = acc_sum;
                  op_a    = z_ff;
                  op_b    = OP_B_W'(signed'({1'b0, rows_ff}));
               end
               5'd24: begin acc_in = ACC_W'(mul_prod); op_a = p1_ff; op_b = OP_B_W'(30); end
               5'd25: begin
                  ynum_in = acc_diff;
                  // eye plane: nothing at or behind z = 0
                  if (z_ff > 0) begin
                     div_req.start = 1'b1;
                     div_req.num   = mag(xnum_ff);
                     div_req.den   = {z_ff, 1'b0};
                     neg_in        = xnum_ff < 0;
                     state_in      = ST_DIVX;
                  end else begin
                     state_in = ST_OUT;
                  end
               end
               default: state_in = ST_OUT;
            endcase
         end

         ST_DIVX: begin
            if (div_rsp.done) begin
               if (q_ok) begin
                  xp_in         = q_val;
                  div_req.start = 1'b1;
                  div_req.num   = mag(ynum_ff);
                  div_req.den   = {z_ff, 1'b0};
                  neg_in        = ynum_ff < 0;
                  state_in      = ST_DIVY;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end

         ST_DIVY: begin
            if (div_rsp.done) begin
               if (q_ok) begin
                  yp_in         = q_val;
                  div_req.start = 1'b1;
                  div_req.num   = OOZ_NUM;
                  div_req.den   = {1'b0, z_ff};
                  state_in      = ST_DIVZ;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end

         ST_DIVZ: begin
            if (div_rsp.done) begin
               // reciprocal depth saturates at full scale
               if (div_rsp.quot > NUM_W'(16'hFFFF)) begin
                  ooz_in = 16'hFFFF;
               end else begin
                  ooz_in = div_rsp.quot[15:0];
               end
               state_in = ST_ADDR;
            end
         end

         ST_ADDR: begin
            op_a     = OP_A_W'(signed'({1'b0, yp_ff}));
            op_b     = OP_B_W'(signed'({1'b0, cols_ff}));
            state_in = ST_ADDR2;
         end

         ST_ADDR2: begin
            o_in      = o_sum;
            mem_raddr = o_sum[PIX_W-1:0];
            if (o_sum < CELL_EXT_W'(FRAME_PIXELS)) begin
               state_in = ST_TEST;
            end else begin
               state_in = ST_OUT;
            end
         end

         // depth test against the stored reciprocal depth
         ST_TEST: begin
            res_cell_in = o_ff[12:0];
            if (ooz_ff > rd_depth_ff) begin
               mem_we      = 1'b1;
               mem_waddr   = o_ff[PIX_W-1:0];
               mem_wchar   = SHADE_CHARS[shade_idx];
               mem_wdepth  = ooz_ff;
               res_char_in = SHADE_CHARS[shade_idx];
               res_plot_in = 1'b1;
            end else begin
               res_char_in = rd_char_ff;
            end
            state_in = ST_OUT;
         end

         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_cell_in  = res_cell_ff;
               rsp_char_in  = res_char_ff;
               rsp_plot_in  = res_plot_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      ct_ff       <= ct_in;
      st_ff       <= st_in;
      cp_ff       <= cp_in;
      sp_ff       <= sp_in;
      pix_ff      <= pix_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      v0_ff       <= v0_in;
      v2_ff       <= v2_in;
      u0_ff       <= u0_in;
      u2_ff       <= u2_in;
      p0_ff       <= p0_in;
      p1_ff       <= p1_in;
      n1_ff       <= n1_in;
      n2_ff       <= n2_in;
      z_ff        <= z_in;
      acc_ff      <= acc_in;
      xnum_ff     <= xnum_in;
      ynum_ff     <= ynum_in;
      neg_ff      <= neg_in;
      xp_ff       <= xp_in;
      yp_ff       <= yp_in;
      ooz_ff      <= ooz_in;
      o_ff        <= o_in;
      res_cell_ff <= res_cell_in;
      res_char_ff <= res_char_in;
      res_plot_ff <= res_plot_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_char_ff <= rsp_char_in;
      rsp_plot_ff <= rsp_plot_in;
   end

   // configuration registers, identity matrix after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         rot0_ff <= 48'h4000_0000_0000;
         rot1_ff <= 48'h0000_4000_0000;
         rot2_ff <= 48'h0000_0000_4000;
         r1_ff   <= 16'd256;
         r2_ff   <= 16'd512;
         vd_ff   <= 16'd1280;
         cols_ff <= 8'd80;
         rows_ff <= 8'd40;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROT_ROW0:      rot0_ff <= csr_wdata;
            CSR_ROT_ROW1:      rot1_ff <= csr_wdata;
            CSR_ROT_ROW2:      rot2_ff <= csr_wdata;
            CSR_MINOR_RADIUS:  r1_ff   <= csr_wdata[15:0];
            CSR_MAJOR_RADIUS:  r2_ff   <= csr_wdata[15:0];
            CSR_VIEW_DISTANCE: vd_ff   <= csr_wdata[15:0];
            CSR_SCREEN_COLS:   cols_ff <= csr_wdata[7:0];
            CSR_SCREEN_ROWS:   rows_ff <= csr_wdata[7:0];
         endcase
      end
   end

   // frame and depth memories, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= mem_wchar;
         depth_mem[mem_waddr] <= mem_wdepth;
      end
      rd_char_ff  <= frame_mem[mem_raddr];
      rd_depth_ff <= depth_mem[mem_raddr];
   end

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.cell_index = rsp_cell_ff;
   assign rsp_chan.char_code  = rsp_char_ff;
   assign rsp_chan.plotted    = rsp_plot_ff;

   // a plotted word always carries a shade character, never blank
   a_plot_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_plot_ff |-> rsp_char_ff != CHAR_SPACE)
      else $error("plotted word with blank character");

   // the divider only finishes while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIVX || state_ff == ST_DIVY ||
                        state_ff == ST_DIVZ))
      else $error("divider done outside a divide state");

   // memories are written only by a clear or a passing depth test
   a_mem_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_IDLE || state_ff == ST_TEST))
      else $error("memory write from unexpected state");

   // a finished result is never dropped while the output register is busy
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && rsp_valid_ff && !rsp_chan.ready |=> state_ff == ST_OUT)
      else $error("result left output state while register busy");
endmodule

// File: test/tb.sv
// self-checking bench for torus_point_zbuffer_plotter_unit: clear, read, plot and no-op words
// depends on tpz_pkg, tpz_channels and the unit itself; holds its own predictor of the unit
module tb;
   import tpz_pkg::*;

   typedef struct {
      logic [12:0] cidx;
      logic [6:0]  ch;
      logic        plt;
   } cell_result_type;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_WAIT  = 250;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tpz_req_if req_if ();
   tpz_rsp_if rsp_if ();

   torus_point_zbuffer_plotter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the configuration registers
   logic [47:0] rot_m [3];
   logic [15:0] r_minor, r_major, view_dist;
   logic [7:0]  cols, rows;
   // shadow of the frame and depth memories
   logic [6:0]  frame_shadow [FRAME_PIXELS];
   logic [15:0] depth_shadow [FRAME_PIXELS];
   // cells cleared since reset
   bit          cleared [FRAME_PIXELS];

   cell_result_type pending_cells [$];
   int  errors = 0;
   int  cycles = 0;
   bit  no_idle;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // cycle counter and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report(input string what);
      $display("mismatch at cycle %0d: %s", cycles, what);
      errors++;
   endtask

   // ---------------------------------------------------------------- predictor

   function automatic longint fl14(input longint x);
      return x >>> 14;   // arithmetic shift floors
   endfunction

   function automatic longint coef(input int row, input int col);
      logic [15:0] c;
      c = rot_m[row][47 - 16*col -: 16];
      return longint'($signed(c));
   endfunction

   function automatic longint rotate_col(input longint a, input longint b, input longint c,
                                         input int col);
      return fl14(a*coef(0, col) + b*coef(1, col) + c*coef(2, col));
   endfunction

   // cell hit by a plot word, -1 when the point is dropped; also its reciprocal depth and shade sum
   function automatic longint plot_target(input logic [15:0] ct16, input logic [15:0] st16,
         input logic [15:0] cp16, input logic [15:0] sp16, output longint ooz,
         output longint lq);
      longint ct, st, cp, sp, cx, cy, v0, v2, u0, u2, p0, p1, p2, n1, n2, z;
      longint w, h, xp, yp, o;
      o   = -1;
      ooz = 0;
      lq  = 0;
      ct = longint'($signed(ct16));
      st = longint'($signed(st16));
      cp = longint'($signed(cp16));
      sp = longint'($signed(sp16));
      w  = longint'(cols);
      h  = longint'(rows);
      cx = longint'(r_major)*16384 + longint'(r_minor)*ct;
      cy = longint'(r_minor)*st;
      v0 = fl14(cx*cp);
      v2 = fl14(cx*sp);
      u0 = fl14(ct*cp);
      u2 = fl14(ct*sp);
      p0 = rotate_col(v0, cy, v2, 0);
      p1 = rotate_col(v0, cy, v2, 1);
      p2 = rotate_col(v0, cy, v2, 2);
      n1 = rotate_col(u0, st, u2, 1);
      n2 = rotate_col(u0, st, u2, 2);
      z  = p2 + longint'(view_dist)*16384;
      if (z > 0) begin
         xp = (w*z + 60*p0) / (2*z);
         yp = (h*z - 30*p1) / (2*z);
         if (xp >= 0 && xp < w && yp >= 0 && yp < h) begin
            if (xp + w*yp < FRAME_PIXELS) begin
               o   = xp + w*yp;
               ooz = (longint'(1) << 34) / z;
               if (ooz > 65535) ooz = 65535;
               lq  = n1 - n2;
            end
         end
      end
      return o;
   endfunction

   // expected result of one word, updating the shadow memories
   function automatic cell_result_type plot_predict(input mode_type m, input logic [15:0] ct16,
         input logic [15:0] st16, input logic [15:0] cp16, input logic [15:0] sp16,
         input logic [12:0] pix);
      cell_result_type r;
      longint o, ooz, lq, li;
      r.cidx = '0;
      r.ch   = CHAR_SPACE;
      r.plt  = 1'b0;
      case (m)
         MODE_CLEAR: begin
            r.cidx = pix;
            frame_shadow[pix] = CHAR_SPACE;
            depth_shadow[pix] = '0;
            cleared[pix]      = 1'b1;
         end
         MODE_READ: begin
            r.cidx = pix;
            r.ch   = frame_shadow[pix];
         end
         MODE_PLOT: begin
            o = plot_target(ct16, st16, cp16, sp16, ooz, lq);
            if (o >= 0) begin
               r.cidx = o[12:0];
               // hidden point leaves the cell as it is
               if (ooz > longint'(depth_shadow[o])) begin
                  li = (lq > 0) ? lq / 2048 : 0;
                  if (li > 11) li = 11;
                  depth_shadow[o] = ooz[15:0];
                  frame_shadow[o] = SHADE_CHARS[li];
                  r.plt = 1'b1;
               end
               r.ch = frame_shadow[o];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers

   // one word on the request channel, prediction queued once it is taken
   task automatic put_word(input mode_type m, input logic [15:0] ct, input logic [15:0] st,
                           input logic [15:0] cp, input logic [15:0] sp,
                           input logic [12:0] pix);
      if (!no_idle && $urandom_range(99) < 13) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.mode        <= m;
      req_if.cos_theta   <= ct;
      req_if.sin_theta   <= st;
      req_if.cos_phi     <= cp;
      req_if.sin_phi     <= sp;
      req_if.pixel_index <= pix;
      do @(posedge clock); while (!req_if.ready);
      pending_cells.push_back(plot_predict(m, ct, st, cp, sp, pix));
   endtask

   // a read or a depth test of a cell never cleared gets a clear of that cell first
   task automatic send_word(input mode_type m, input logic [15:0] ct, input logic [15:0] st,
                            input logic [15:0] cp, input logic [15:0] sp,
                            input logic [12:0] pix);
      longint tgt, ooz, lq;
      tgt = -1;
      if (m == MODE_PLOT)
         tgt = plot_target(ct, st, cp, sp, ooz, lq);
      else if (m == MODE_READ)
         tgt = longint'(pix);
      if (tgt >= 0 && !cleared[tgt])
         put_word(MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, tgt[12:0]);
      put_word(m, ct, st, cp, sp, pix);
   endtask

   // lower valid once stimulus pauses, then wait for every word to come back
   task automatic drain_words();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // all registers written back to back while the unit is idle
   task automatic set_config(input logic [47:0] m0, input logic [47:0] m1,
                             input logic [47:0] m2, input logic [15:0] rmin,
                             input logic [15:0] rmaj, input logic [15:0] vd,
                             input logic [7:0] w, input logic [7:0] h);
      logic [47:0] vals [8];
      vals = '{m0, m1, m2, 48'(rmin), 48'(rmaj), 48'(vd), 48'(w), 48'(h)};
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      rot_m[0] = m0; rot_m[1] = m1; rot_m[2] = m2;
      r_minor = rmin; r_major = rmaj; view_dist = vd;
      cols = w; rows = h;
   endtask

   function automatic logic [15:0] q14(input real x);
      int v;
      v = $rtoi(x * 16384.0 + (x >= 0.0 ? 0.5 : -0.5));
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      return 16'(v);
   endfunction

   // rotation about x by a, then z by b, packed as three rows
   task automatic set_rotation(input real a, input real b, input logic [15:0] rmin,
                               input logic [15:0] rmaj, input logic [15:0] vd,
                               input logic [7:0] w, input logic [7:0] h);
      real ca, sa, cb, sb;
      ca = $cos(a); sa = $sin(a); cb = $cos(b); sb = $sin(b);
      set_config({q14(cb), q14(sb), 16'h0000},
                 {q14(-ca*sb), q14(ca*cb), q14(sa)},
                 {q14(sa*sb), q14(-sa*cb), q14(ca)}, rmin, rmaj, vd, w, h);
   endtask

   // one plot word from real angles
   task automatic plot_angles(input real th, input real ph);
      send_word(MODE_PLOT, q14($cos(th)), q14($sin(th)), q14($cos(ph)), q14($sin(ph)), '0);
   endtask

   // mix of well-formed surface samples, reads, clears and raw noise
   task automatic mixed_words(input int n);
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 70)
            plot_angles($urandom_range(6283) / 1000.0, $urandom_range(6283) / 1000.0);
         else if (pick < 80)
            send_word(MODE_READ, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      13'($urandom));
         else if (pick < 85)
            send_word(MODE_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 13'($urandom));
         else if (pick < 97)
            send_word(MODE_PLOT, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      13'($urandom));
         else
            send_word(MODE_NONE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      13'($urandom));
      end
      drain_words();
   endtask

   // ---------------------------------------------------------------- tests

   // a strip of 32 cells cleared and every fourth read back; other cells are cleared on first use
   task automatic test_clear_frame();
      for (int i = 0; i < 32; i++)
         send_word(MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 13'(i));
      for (int i = 0; i < 32; i += 4)
         send_word(MODE_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 13'(i));
      drain_words();
   endtask

   task automatic test_directed();
      send_word(MODE_NONE, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 13'h1fff);
      send_word(MODE_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 13'h0000);
      send_word(MODE_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 13'h1fff);
      // extremes of the trig fields
      send_word(MODE_PLOT, 16'h4000, 16'h0000, 16'h4000, 16'h0000, '0);
      send_word(MODE_PLOT, 16'h4000, 16'h0000, 16'h4000, 16'h0000, '0);   // hidden point
      send_word(MODE_PLOT, 16'hc000, 16'hc000, 16'hc000, 16'hc000, '0);
      send_word(MODE_PLOT, 16'h0000, 16'h4000, 16'h0000, 16'h4000, '0);
      send_word(MODE_PLOT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, '0);
      send_word(MODE_PLOT, 16'h4000, 16'h4000, 16'hc000, 16'h4000, '0);
      send_word(MODE_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 13'd1220);
      send_word(MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 13'h1fff);
      send_word(MODE_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 13'h1fff);
      drain_words();
      // eye plane: no view distance puts the near half behind the eye
      set_rotation(0.0, 0.0, 16'h0100, 16'h0200, 16'h0000, 8'd80, 8'd40);
      plot_angles(0.0, 1.57);
      plot_angles(0.0, -1.57);
      plot_angles(3.14, 0.0);
      drain_words();
      // one-cell frame: nearly everything is off screen
      set_rotation(0.0, 0.0, 16'h0100, 16'h0200, 16'h0500, 8'd1, 8'd1);
      plot_angles(0.0, 0.0);
      plot_angles(1.0, 2.0);
      plot_angles(3.14, 3.14);
      drain_words();
   endtask

   task automatic test_random_views();
      for (int k = 0; k < 8; k++) begin
         set_rotation($urandom_range(6283) / 1000.0, $urandom_range(6283) / 1000.0,
                      16'($urandom_range(512, 128)), 16'($urandom_range(768, 256)),
                      16'($urandom_range(2048, 768)), 8'($urandom_range(255, 30)),
                      8'($urandom_range(100, 15)));
         mixed_words(70);
      end
   endtask

   // a long stretch without any idling on either side
   task automatic test_back_to_back();
      no_idle = 1'b1;
      set_rotation(0.7, 1.1, 16'h0100, 16'h0200, 16'h0500, 8'd80, 8'd40);
      mixed_words(90);
      no_idle = 1'b0;
   endtask

   task automatic test_config_extremes();
      // widest frame, largest radii and distance
      set_rotation(0.3, 0.9, 16'hffff, 16'hffff, 16'hffff, 8'd255, 8'd255);
      mixed_words(40);
      set_rotation(1.2, 0.4, 16'h0000, 16'h0000, 16'h0000, 8'd255, 8'd255);
      mixed_words(25);
      // most negative and all-ones coefficients
      set_config({3{16'h8000}}, {3{16'hffff}}, {3{16'h8000}},
                 16'h0100, 16'h0200, 16'h0500, 8'd80, 8'd40);
      mixed_words(25);
      // raw random registers
      for (int k = 0; k < 4; k++) begin
         set_config(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                    48'({$urandom, $urandom}), 16'($urandom), 16'($urandom),
                    16'($urandom), 8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)));
         mixed_words(25);
      end
      set_config(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                 48'({$urandom, $urandom}), 16'h5555, 16'haaaa, 16'h00ff, 8'h55, 8'haa);
      mixed_words(15);
      set_rotation(0.0, 0.0, 16'haaaa, 16'h5555, 16'hff00, 8'haa, 8'h55);
      mixed_words(15);
   endtask

   // ---------------------------------------------------------------- response side

   always @(posedge clock) begin
      cell_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_cells.size() == 0) begin
               report("result word with nothing expected");
            end else begin
               want = pending_cells.pop_front();
               if (rsp_if.cell_index !== want.cidx)
                  report($sformatf("cell_index %0d, expected %0d", rsp_if.cell_index,
                                   want.cidx));
               if (rsp_if.char_code !== want.ch)
                  report($sformatf("char_code %0h, expected %0h", rsp_if.char_code, want.ch));
               if (rsp_if.plotted !== want.plt)
                  report($sformatf("plotted %0b, expected %0b", rsp_if.plotted, want.plt));
            end
         end
         rsp_if.ready <= no_idle || ($urandom_range(99) >= 13);
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      no_idle = 1'b0;
      reset   <= 1'b1;
      csr_we  <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_if.valid       <= 1'b0;
      req_if.mode        <= MODE_NONE;
      req_if.cos_theta   <= '0;
      req_if.sin_theta   <= '0;
      req_if.cos_phi     <= '0;
      req_if.sin_phi     <= '0;
      req_if.pixel_index <= '0;
      // reset values of the registers
      rot_m[0] = 48'h4000_0000_0000;
      rot_m[1] = 48'h0000_4000_0000;
      rot_m[2] = 48'h0000_0000_4000;
      r_minor = 16'd256; r_major = 16'd512; view_dist = 16'd1280;
      cols = 8'd80; rows = 8'd40;
      for (int i = 0; i < FRAME_PIXELS; i++) begin
         frame_shadow[i] = '0;
         depth_shadow[i] = '0;
         cleared[i]      = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_clear_frame();
      test_directed();
      test_random_views();
      test_back_to_back();
      test_config_extremes();

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: torus_point_zbuffer_plotter_unit.f
sv/tpz_pkg.sv
sv/tpz_channels.sv
sv/tpz_mul.sv
sv/tpz_div.sv
sv/torus_point_zbuffer_plotter_unit.sv
test/tb.sv
